// File: rtl/rrp_pkg.sv
// Row record parser package: parse phase, byte role, type tag and error codes,
// plus the parse state and per-byte result structs.
// No dependencies.
package rrp_pkg;

    // parse phases
    localparam logic [3:0] PH_CNT_LO = 4'd0;
    localparam logic [3:0] PH_CNT_HI = 4'd1;
    localparam logic [3:0] PH_NL_LO  = 4'd2;
    localparam logic [3:0] PH_NL_HI  = 4'd3;
    localparam logic [3:0] PH_NAME   = 4'd4;
    localparam logic [3:0] PH_TAG    = 4'd5;
    localparam logic [3:0] PH_VALUE  = 4'd6;
    localparam logic [3:0] PH_SLEN   = 4'd7;
    localparam logic [3:0] PH_SBODY  = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;
    localparam logic [3:0] PH_IGNORE = 4'd10;

    // byte roles
    localparam logic [2:0] ROLE_COUNT   = 3'd0;
    localparam logic [2:0] ROLE_NAMELEN = 3'd1;
    localparam logic [2:0] ROLE_NAME    = 3'd2;
    localparam logic [2:0] ROLE_TAG     = 3'd3;
    localparam logic [2:0] ROLE_VALUE   = 3'd4;
    localparam logic [2:0] ROLE_STRLEN  = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    // type tags
    localparam logic [2:0] TYPE_NULL = 3'd0;
    localparam logic [2:0] TYPE_I64  = 3'd1;
    localparam logic [2:0] TYPE_F64  = 3'd2;
    localparam logic [2:0] TYPE_BOOL = 3'd3;
    localparam logic [2:0] TYPE_STR  = 3'd4;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NAMELEN   = 4'd1;
    localparam logic [3:0] ERR_NAME      = 4'd2;
    localparam logic [3:0] ERR_TAG       = 4'd3;
    localparam logic [3:0] ERR_I64       = 4'd4;
    localparam logic [3:0] ERR_F64       = 4'd5;
    localparam logic [3:0] ERR_BOOL      = 4'd6;
    localparam logic [3:0] ERR_STRLEN    = 4'd7;
    localparam logic [3:0] ERR_STRBODY   = 4'd8;
    localparam logic [3:0] ERR_BADTAG    = 4'd9;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  count_low;
        logic [15:0] columns_total;
        logic [15:0] current_column;
        logic [31:0] bytes_left;
        logic [2:0]  current_type;
        logic [63:0] acc;
        logic [2:0]  byte_pos;
        logic [3:0]  error;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_CNT_LO,
        count_low:      8'd0,
        columns_total:  16'd0,
        current_column: 16'd0,
        bytes_left:     32'd0,
        current_type:   TYPE_NULL,
        acc:            64'd0,
        byte_pos:       3'd0,
        error:          ERR_NONE
    };

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  data_out;
        logic [15:0] column_index;
        logic [2:0]  value_type;
        logic        column_done;
        logic [63:0] column_value;
        logic        record_done;
        logic [15:0] column_count;
        logic [3:0]  error_code;
    } t_result;

endpackage

// File: rtl/rrp_step.sv
// Row record parser next-state logic: one byte against the current parse state
// gives the next state and the byte's result.
// Depends on rrp_pkg.
module rrp_step (
    input  rrp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output rrp_pkg::t_state  o_state,
    output rrp_pkg::t_result o_result
);
    import rrp_pkg::*;

    t_state      nxt;
    logic [2:0]  role;
    logic [15:0] col;
    logic [2:0]  vt;
    logic        fin;
    logic [63:0] fin_val;
    logic [63:0] acc_lane;
    logic [63:0] acc_slen;
    logic [31:0] dec;
    logic [15:0] col_inc;
    logic [15:0] total_new;
    logic [15:0] nlen_word;
    logic [3:0]  err;

    assign acc_lane  = i_state.acc | (64'(i_byte) << {i_state.byte_pos, 3'b000});
    assign acc_slen  = i_state.acc | (64'(i_byte) << {1'b0, i_state.byte_pos[1:0], 3'b000});
    assign dec       = i_state.bytes_left - 32'd1;
    assign col_inc   = i_state.current_column + 16'd1;
    assign total_new = {i_byte, i_state.count_low};
    assign nlen_word = {i_byte, i_state.acc[7:0]};

    always_comb begin
        nxt     = i_state;
        role    = ROLE_IGNORED;
        col     = '0;
        vt      = TYPE_NULL;
        fin     = 1'b0;
        fin_val = '0;

        unique case (i_state.phase)
            PH_CNT_LO: begin
                role          = ROLE_COUNT;
                nxt.count_low = i_byte;
                nxt.phase     = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                role               = ROLE_COUNT;
                nxt.columns_total  = total_new;
                nxt.current_column = '0;
                nxt.phase          = (total_new != '0) ? PH_NL_LO : PH_DONE;
            end
            PH_NL_LO: begin
                role    = ROLE_NAMELEN;
                col     = i_state.current_column;
                nxt.acc = 64'(i_byte);
                nxt.phase = PH_NL_HI;
            end
            PH_NL_HI: begin
                role           = ROLE_NAMELEN;
                col            = i_state.current_column;
                nxt.bytes_left = 32'(nlen_word);
                nxt.phase      = (nlen_word != '0) ? PH_NAME : PH_TAG;
            end
            PH_NAME: begin
                role           = ROLE_NAME;
                col            = i_state.current_column;
                nxt.bytes_left = dec;
                if (dec == '0) begin
                    nxt.phase = PH_TAG;
                end
            end
            PH_TAG: begin
                role = ROLE_TAG;
                col  = i_state.current_column;
                if (i_byte <= 8'(TYPE_STR)) begin
                    nxt.current_type = i_byte[2:0];
                    vt               = i_byte[2:0];
                    nxt.acc          = '0;
                    nxt.byte_pos     = '0;
                    if (i_byte[2:0] == TYPE_NULL) begin
                        fin = 1'b1;
                    end else if (i_byte[2:0] == TYPE_STR) begin
                        nxt.phase = PH_SLEN;
                    end else begin
                        nxt.phase = PH_VALUE;
                    end
                end else begin
                    nxt.error = ERR_BADTAG;
                    nxt.phase = PH_IGNORE;
                end
            end
            PH_VALUE: begin
                role = ROLE_VALUE;
                col  = i_state.current_column;
                vt   = i_state.current_type;
                if (i_state.current_type == TYPE_BOOL) begin
                    fin     = 1'b1;
                    fin_val = 64'(i_byte != 8'd0);
                end else begin
                    nxt.acc = acc_lane;
                    if (i_state.byte_pos == 3'd7) begin
                        fin     = 1'b1;
                        fin_val = acc_lane;
                    end else begin
                        nxt.byte_pos = i_state.byte_pos + 3'd1;
                    end
                end
            end
            PH_SLEN: begin
                role    = ROLE_STRLEN;
                col     = i_state.current_column;
                vt      = i_state.current_type;
                nxt.acc = acc_slen;
                if (i_state.byte_pos >= 3'd3) begin
                    nxt.bytes_left = acc_slen[31:0];
                    if (acc_slen[31:0] == '0) begin
                        fin = 1'b1;
                    end else begin
                        nxt.phase = PH_SBODY;
                    end
                end else begin
                    nxt.byte_pos = i_state.byte_pos + 3'd1;
                end
            end
            PH_SBODY: begin
                role           = ROLE_VALUE;
                col            = i_state.current_column;
                vt             = i_state.current_type;
                nxt.bytes_left = dec;
                if (dec == '0) begin
                    fin     = 1'b1;
                    fin_val = {32'd0, i_state.acc[31:0]};
                end
            end
            default: begin
                role = ROLE_IGNORED;
            end
        endcase

        if (fin) begin
            nxt.current_column = col_inc;
            nxt.phase = (col_inc >= i_state.columns_total) ? PH_DONE : PH_NL_LO;
        end
    end

    // truncation error named by the element still expected at the last byte
    always_comb begin
        err = nxt.error;
        if (i_last && (nxt.error == ERR_NONE)) begin
            unique case (nxt.phase)
                PH_NL_LO, PH_NL_HI: err = ERR_NAMELEN;
                PH_NAME:            err = ERR_NAME;
                PH_TAG:             err = ERR_TAG;
                PH_VALUE: begin
                    err = (nxt.current_type == TYPE_I64) ? ERR_I64 :
                          (nxt.current_type == TYPE_F64) ? ERR_F64 : ERR_BOOL;
                end
                PH_SLEN:            err = ERR_STRLEN;
                PH_SBODY:           err = ERR_STRBODY;
                default:            err = nxt.error;
            endcase
        end
    end

    assign o_state = i_last ? STATE_RESET : nxt;

    assign o_result = '{
        byte_role:    role,
        data_out:     i_byte,
        column_index: col,
        value_type:   vt,
        column_done:  fin,
        column_value: fin_val,
        record_done:  i_last,
        column_count: i_last ? nxt.columns_total : 16'd0,
        error_code:   err
    };

endmodule

// File: rtl/row_record_parser.sv
// Row record parser: classifies each byte of a little-endian row record.
// The result of an accepted item is registered and shown on the master side in the next cycle.
// Throughput: 1 item per cycle while the master side is ready; the parse state updates once per byte.
// The output register lets a new item in while the held result drains.
// Reset: synchronous, active low; parse state returns to count-low-byte expected.
module row_record_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic           s_axis_tlast,   // last_byte
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // [7:0] data_out, [23:8] column_index, [26:24] value_type, [27] column_done,
    // [91:28] column_value, [107:92] column_count, [111:108] error_code
    output logic [111:0]   m_axis_tdata,
    output logic [2:0]     m_axis_tuser,   // [2:0] byte_role
    output logic           m_axis_tlast    // record_done
);
    import rrp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_m_valid;
    logic    s_accept;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    rrp_step u_step (
        .i_state  (r_state),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= STATE_RESET;
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_state   <= n_state;
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_result.error_code, r_result.column_count,
                            r_result.column_value, r_result.column_done,
                            r_result.value_type, r_result.column_index,
                            r_result.data_out};
    assign m_axis_tuser  = r_result.byte_role;
    assign m_axis_tlast  = r_result.record_done;

`ifndef ASSERT_OFF
    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_result.column_done) |->
        (r_result.byte_role == ROLE_TAG || r_result.byte_role == ROLE_VALUE ||
         r_result.byte_role == ROLE_STRLEN))
        else $error("column finished on a byte that cannot end a column");

    a_count_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_result.record_done) |-> (r_result.column_count == 16'd0))
        else $error("column count shown before record end");

    a_value_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_result.column_done) |-> (r_result.column_value == 64'd0))
        else $error("column value shown without column done");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tlast) |=> (r_state.phase == PH_CNT_LO &&
                                        r_state.error == ERR_NONE))
        else $error("parser did not restart after record end");
`endif

endmodule

// File: tb/tb_row_record_parser.sv
// Self-checking testbench for row_record_parser: feeds directed and random row records
// byte by byte and checks every result item against a local model of the parser.
// Depends on rrp_pkg and row_record_parser from the rtl folder.
module tb_row_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 1600;
    localparam int DRAIN_CYCLES   = 4;

    // receiver stall patterns
    localparam int RDY_ALWAYS   = 0;
    localparam int RDY_COIN     = 1;
    localparam int RDY_SPARSE   = 2;
    localparam int RDY_PERIODIC = 3;

    // Tracks parser state and holds the results still owed by the block.
    class record_scoreboard;
        t_state  st;
        t_result owed_q[$];
        int      errors;
        int      records;
        int      bytes_seen;
        int      columns_closed;
        int      end_codes[16];

        function new();
            st = STATE_RESET;
            errors = 0;
            records = 0;
            bytes_seen = 0;
            columns_closed = 0;
            foreach (end_codes[i]) end_codes[i] = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void close_column(inout t_result r, input logic [63:0] v);
            r.column_done = 1'b1;
            r.column_value = v;
            st.current_column = st.current_column + 16'd1;
            st.phase = (st.current_column >= st.columns_total) ? PH_DONE : PH_NL_LO;
        endfunction

        function t_result parse_byte(logic [7:0] b, logic lst);
            t_result r;
            r = '0;
            r.byte_role = ROLE_IGNORED;
            r.data_out = b;
            r.record_done = lst;
            case (st.phase)
                PH_CNT_LO: begin
                    r.byte_role = ROLE_COUNT;
                    st.count_low = b;
                    st.phase = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    r.byte_role = ROLE_COUNT;
                    st.columns_total = {b, st.count_low};
                    st.current_column = '0;
                    st.phase = (st.columns_total != 0) ? PH_NL_LO : PH_DONE;
                end
                PH_NL_LO: begin
                    r.byte_role = ROLE_NAMELEN;
                    r.column_index = st.current_column;
                    st.acc = {56'd0, b};
                    st.phase = PH_NL_HI;
                end
                PH_NL_HI: begin
                    r.byte_role = ROLE_NAMELEN;
                    r.column_index = st.current_column;
                    st.bytes_left = {16'd0, b, st.acc[7:0]};
                    st.phase = (st.bytes_left != 0) ? PH_NAME : PH_TAG;
                end
                PH_NAME: begin
                    r.byte_role = ROLE_NAME;
                    r.column_index = st.current_column;
                    st.bytes_left = st.bytes_left - 32'd1;
                    if (st.bytes_left == 0) st.phase = PH_TAG;
                end
                PH_TAG: begin
                    r.byte_role = ROLE_TAG;
                    r.column_index = st.current_column;
                    if (b <= 8'(TYPE_STR)) begin
                        st.current_type = b[2:0];
                        r.value_type = b[2:0];
                        st.acc = '0;
                        st.byte_pos = '0;
                        if (b[2:0] == TYPE_NULL) close_column(r, 64'd0);
                        else if (b[2:0] == TYPE_STR) st.phase = PH_SLEN;
                        else st.phase = PH_VALUE;
                    end else begin
                        st.error = ERR_BADTAG;
                        st.phase = PH_IGNORE;
                    end
                end
                PH_VALUE: begin
                    r.byte_role = ROLE_VALUE;
                    r.column_index = st.current_column;
                    r.value_type = st.current_type;
                    if (st.current_type == TYPE_BOOL) begin
                        close_column(r, {63'd0, b != 8'd0});
                    end else begin
                        st.acc = st.acc | ({56'd0, b} << (st.byte_pos * 8));
                        if (st.byte_pos == 3'd7) close_column(r, st.acc);
                        else st.byte_pos = st.byte_pos + 3'd1;
                    end
                end
                PH_SLEN: begin
                    r.byte_role = ROLE_STRLEN;
                    r.column_index = st.current_column;
                    r.value_type = st.current_type;
                    st.acc = st.acc | ({56'd0, b} << (st.byte_pos[1:0] * 8));
                    if (st.byte_pos >= 3'd3) begin
                        st.bytes_left = st.acc[31:0];
                        if (st.bytes_left == 0) close_column(r, 64'd0);
                        else st.phase = PH_SBODY;
                    end else begin
                        st.byte_pos = st.byte_pos + 3'd1;
                    end
                end
                PH_SBODY: begin
                    r.byte_role = ROLE_VALUE;
                    r.column_index = st.current_column;
                    r.value_type = st.current_type;
                    st.bytes_left = st.bytes_left - 32'd1;
                    if (st.bytes_left == 0) close_column(r, {32'd0, st.acc[31:0]});
                end
                default: r.byte_role = ROLE_IGNORED;
            endcase

            if (lst) begin
                r.column_count = st.columns_total;
                // a cut-short record names the element it was waiting for
                if (st.error == ERR_NONE) begin
                    case (st.phase)
                        PH_NL_LO, PH_NL_HI: st.error = ERR_NAMELEN;
                        PH_NAME:            st.error = ERR_NAME;
                        PH_TAG:             st.error = ERR_TAG;
                        PH_VALUE:
                            st.error = (st.current_type == TYPE_I64) ? ERR_I64 :
                                       (st.current_type == TYPE_F64) ? ERR_F64 : ERR_BOOL;
                        PH_SLEN:            st.error = ERR_STRLEN;
                        PH_SBODY:           st.error = ERR_STRBODY;
                        default:            ;
                    endcase
                end
            end
            r.error_code = st.error;
            if (lst) st = STATE_RESET;
            return r;
        endfunction

        function void note_input(logic [7:0] b, logic lst);
            t_result r;
            r = parse_byte(b, lst);
            owed_q = {owed_q, r};
            bytes_seen++;
            if (r.column_done) columns_closed++;
            if (lst) begin
                records++;
                end_codes[r.error_code]++;
            end
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (owed_q.size() == 0) begin
                $error("result item with no item pending: role %0d data 0x%0h",
                       got.byte_role, got.data_out);
                errors++;
                return;
            end
            exp_r = owed_q.pop_front();
            compare_field("byte_role",    64'(exp_r.byte_role),    64'(got.byte_role));
            compare_field("data_out",     64'(exp_r.data_out),     64'(got.data_out));
            compare_field("column_index", 64'(exp_r.column_index), 64'(got.column_index));
            compare_field("value_type",   64'(exp_r.value_type),   64'(got.value_type));
            compare_field("column_done",  64'(exp_r.column_done),  64'(got.column_done));
            compare_field("column_value", exp_r.column_value,      got.column_value);
            compare_field("record_done",  64'(exp_r.record_done),  64'(got.record_done));
            compare_field("column_count", 64'(exp_r.column_count), 64'(got.column_count));
            compare_field("error_code",   64'(exp_r.error_code),   64'(got.error_code));
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata = '0;   // [7:0] data_byte
    logic           s_axis_tlast = 1'b0; // last_byte
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // [7:0] data_out, [23:8] column_index, [26:24] value_type, [27] column_done,
    // [91:28] column_value, [107:92] column_count, [111:108] error_code
    logic [111:0]   m_axis_tdata;
    logic [2:0]     m_axis_tuser;        // [2:0] byte_role
    logic           m_axis_tlast;        // record_done

    record_scoreboard sb = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int ready_mode = RDY_ALWAYS;
    int ready_left = 0;
    int ready_tick = 0;

    row_record_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // receiver: switches between stall patterns
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            RDY_ALWAYS:   m_axis_tready <= 1'b1;
            RDY_COIN:     m_axis_tready <= $urandom_range(0, 1);
            RDY_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:      m_axis_tready <= (ready_tick % 3) != 0;
        endcase
    end

    // item monitor on both sides
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.byte_role    = m_axis_tuser;
                got.data_out     = m_axis_tdata[7:0];
                got.column_index = m_axis_tdata[23:8];
                got.value_type   = m_axis_tdata[26:24];
                got.column_done  = m_axis_tdata[27];
                got.column_value = m_axis_tdata[91:28];
                got.record_done  = m_axis_tlast;
                got.column_count = m_axis_tdata[107:92];
                got.error_code   = m_axis_tdata[111:108];
                sb.check_result(got);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_row_record_parser: done, errors");
            $finish;
        end
    end

    // sender works in bursts separated by random gaps
    task automatic send_byte(logic [7:0] b, logic lst);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_record(ref logic [7:0] rec[$]);
        foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
    endtask

    // builds one random record: mostly well formed, some cut short, some noise
    task automatic build_record(ref logic [7:0] rec[$], output int useful);
        int kind, gen_cols, nlen, pick;
        logic [15:0] count;
        logic [31:0] len32;
        logic [63:0] v;
        logic [7:0] tag;
        bit stop, cut_short;
        rec.delete();
        useful = 0;
        stop = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) rec = {rec, 8'($urandom)};
            useful = rec.size();
            return;
        end
        if (kind < 15) begin
            if ($urandom_range(0, 1)) begin
                rec = {rec, 8'($urandom)};
            end else begin
                rec = {rec, 8'd0};
                rec = {rec, 8'd0};
            end
            useful = rec.size();
            if ($urandom_range(0, 1)) rec = {rec, 8'($urandom)};
            return;
        end
        cut_short = (kind < 30);
        count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
        rec = {rec, count[7:0]};
        rec = {rec, count[15:8]};
        gen_cols = (count > 16'd4) ? 4 : int'(count);
        for (int c = 0; c < gen_cols && !stop; c++) begin
            nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            rec = {rec, 8'(nlen)};
            rec = {rec, 8'(nlen >> 8)};
            repeat (nlen) rec = {rec, 8'($urandom)};
            if ($urandom_range(0, 19) == 0) begin
                // unknown tag: the rest of the record is skipped
                rec = {rec, 8'($urandom_range(5, 255))};
                repeat ($urandom_range(0, 4)) rec = {rec, 8'($urandom)};
                stop = 1'b1;
            end else begin
                tag = 8'($urandom_range(TYPE_NULL, TYPE_STR));
                rec = {rec, tag};
                case (tag[2:0])
                    TYPE_I64, TYPE_F64: begin
                        pick = $urandom_range(0, 3);
                        v = (pick == 0) ? 64'd0 :
                            (pick == 1) ? '1 :
                            (pick == 2) ? 64'h8000_0000_0000_0000 : {$urandom, $urandom};
                        for (int k = 0; k < 8; k++) rec = {rec, v[k*8 +: 8]};
                    end
                    TYPE_BOOL: begin
                        pick = $urandom_range(0, 2);
                        rec = {rec, (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : 8'($urandom)};
                    end
                    TYPE_STR: begin
                        if ($urandom_range(0, 7) == 0) begin
                            // long string: record ends inside the body
                            len32 = $urandom | 32'h100;
                            for (int k = 0; k < 4; k++) rec = {rec, len32[k*8 +: 8]};
                            repeat ($urandom_range(1, 4)) rec = {rec, 8'($urandom)};
                            stop = 1'b1;
                        end else begin
                            len32 = $urandom_range(0, 5);
                            for (int k = 0; k < 4; k++) rec = {rec, len32[k*8 +: 8]};
                            repeat (len32) rec = {rec, 8'($urandom)};
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (cut_short && rec.size() > 1)
            rec = rec[0:$urandom_range(0, rec.size() - 2)];
        useful = rec.size();
        if (!stop && !cut_short && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) rec = {rec, 8'($urandom)};
    endtask

    initial begin : main
        logic [7:0] rec[$];
        int useful;
        int random_bytes;
        string codes;
        random_bytes = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single byte record, then zero-column records with and without a trailing byte
        rec = '{8'h5a};                                       send_record(rec);
        rec = '{8'h00, 8'h00};                                send_record(rec);
        rec = '{8'h00, 8'h00, 8'hab};                         send_record(rec);
        // empty name, empty string, trailing byte
        rec = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h04,
                8'h00, 8'h00, 8'h00, 8'h00, 8'hee};           send_record(rec);
        // unknown tag, later bytes skipped
        rec = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hff, 8'h12};   send_record(rec);
        // largest count and name length, cut inside the name
        rec = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h80};          send_record(rec);

        while (random_bytes < RANDOM_BYTES) begin
            build_record(rec, useful);
            send_record(rec);
            random_bytes += useful;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        codes = "";
        foreach (sb.end_codes[i])
            if (sb.end_codes[i] != 0) codes = {codes, $sformatf(" %0d:%0d", i, sb.end_codes[i])};
        $display("covered %0d records, %0d bytes, %0d columns closed",
                 sb.records, sb.bytes_seen, sb.columns_closed);
        $display("record ends by error code (code:count):%s", codes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_row_record_parser: done, clean");
        else
            $display("tb_row_record_parser: done, errors");
        $finish;
    end
endmodule
